>>> src/ufsc_pkg.sv
// shared types and constants for the udp flow size counter
package ufsc_pkg;
	localparam logic [1:0] STATUS_IGNORED = 2'd0;
	localparam logic [1:0] STATUS_COUNTED = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [3:0]  MIN_IHL        = 4'd5;
	localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
	localparam logic [6:0]  POS_MAX        = 7'd127;

	localparam logic REG_PORT_LOW  = 1'b0;
	localparam logic REG_PORT_HIGH = 1'b1;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] dest_addr;
		logic [15:0] payload_len;
		logic [63:0] frame_count;
	} out_beat_t;
endpackage

>>> src/ufsc_if.sv
// valid/ready channel interfaces for input and result beats
interface ufsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_end;
	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface ufsc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] dest_addr;
	logic [15:0] payload_len;
	logic [63:0] frame_count;
	modport source (output valid, output status, output dest_addr, output payload_len,
		output frame_count, input ready);
	modport sink (input valid, input status, input dest_addr, input payload_len,
		input frame_count, output ready);
endinterface

>>> src/udp_flow_size_counter.sv
// top level: ipv4/udp header parser and per-flow frame counter
// Frame bytes are taken one per cycle while no frame end is being resolved and the
// output register is empty. On the last byte of a matching frame the flow table (key
// and count memories, one entry read per cycle) is searched linearly, each entry read
// and then compared, over at most the N entries in use (N at most TABLE_ENTRIES);
// input is held off meanwhile. An ignored frame is resolved without a search.
// The result waits in an output register. The table starts empty after reset and
// needs no clearing pass.
module udp_flow_size_counter #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	ufsc_in_if.sink     in_ch,
	ufsc_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import ufsc_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

	localparam logic [2:0] ST_RX = 3'd0, ST_RD = 3'd1, ST_CMP = 3'd2, ST_WR = 3'd3,
		ST_OUT = 3'd4, ST_WAIT = 3'd5;

	logic [15:0] port_low_q, port_high_q;
	logic [6:0]  pos_q;
	logic [15:0] ether_type_q, src_port_q, udp_length_q;
	logic [3:0]  header_words_q;
	logic [7:0]  proto_q;
	logic [31:0] dest_q;
	logic [CW-1:0] used_q, idx_q;
	logic [2:0]  state_q;
	logic [47:0] key_q;
	logic [47:0] mem_key [TABLE_ENTRIES];
	logic [63:0] mem_cnt [TABLE_ENTRIES];
	logic [47:0] rd_key_q;
	logic [63:0] rd_cnt_q;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [63:0] wr_cnt;
	logic        out_valid_q;
	out_beat_t   out_q;

	logic        take;
	logic [7:0]  u_pos;
	logic        in_udp;
	logic [7:0]  len;
	logic        ok;
	logic [15:0] payload;

	assign in_ch.ready = (state_q == ST_RX) && !out_valid_q;
	assign take = in_ch.valid && in_ch.ready;
	assign u_pos = 8'd14 + {2'b0, header_words_q, 2'b0};
	assign in_udp = (header_words_q >= MIN_IHL) && (pos_q > 7'd14);
	assign len = {1'b0, pos_q} + 8'd1;
	assign payload = udp_length_q - UDP_HDR_LEN;
	assign ok = (ether_type_q == ETHERTYPE_IPV4) && (len >= 8'd34) && (proto_q == PROTO_UDP)
		&& (header_words_q >= MIN_IHL) && ({1'b0, len} >= {1'b0, u_pos} + 9'd8)
		&& (src_port_q >= port_low_q) && (src_port_q <= port_high_q)
		&& (udp_length_q >= UDP_HDR_LEN);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_key[wr_addr] <= key_q;
			mem_cnt[wr_addr] <= wr_cnt;
		end
		rd_key_q <= mem_key[idx_q[AW-1:0]];
		rd_cnt_q <= mem_cnt[idx_q[AW-1:0]];
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_cnt = rd_cnt_q + 64'd1;
		if (state_q == ST_CMP && rd_key_q == key_q) begin
			wr_en = 1'b1;
		end else if (state_q == ST_WR && used_q != FULL) begin
			wr_en = 1'b1;
			wr_addr = used_q[AW-1:0];
			wr_cnt = 64'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_low_q <= 16'd27960;
			port_high_q <= 16'd27963;
			pos_q <= '0;
			ether_type_q <= '0;
			header_words_q <= '0;
			proto_q <= '0;
			dest_q <= '0;
			src_port_q <= '0;
			udp_length_q <= '0;
			used_q <= '0;
			idx_q <= '0;
			state_q <= ST_RX;
			key_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PORT_LOW) port_low_q <= cfg_data;
				else port_high_q <= cfg_data;
			end
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_RX: begin
					if (take) begin
						if (pos_q == 7'd12 || pos_q == 7'd13)
							ether_type_q <= {ether_type_q[7:0], in_ch.frame_byte};
						if (pos_q == 7'd14) header_words_q <= in_ch.frame_byte[3:0];
						if (pos_q == 7'd23) proto_q <= in_ch.frame_byte;
						if (pos_q >= 7'd30 && pos_q <= 7'd33)
							dest_q <= {dest_q[23:0], in_ch.frame_byte};
						if (in_udp && ({1'b0, pos_q} == u_pos || {1'b0, pos_q} == u_pos + 8'd1))
							src_port_q <= {src_port_q[7:0], in_ch.frame_byte};
						if (in_udp && ({1'b0, pos_q} == u_pos + 8'd4
							|| {1'b0, pos_q} == u_pos + 8'd5))
							udp_length_q <= {udp_length_q[7:0], in_ch.frame_byte};
						if (in_ch.frame_end) begin
							state_q <= ST_RD;
						end else if (pos_q != POS_MAX) begin
							pos_q <= pos_q + 7'd1;
						end
					end
				end
				ST_RD: begin
					key_q <= {dest_q, payload};
					idx_q <= '0;
					pos_q <= '0;
					ether_type_q <= '0;
					header_words_q <= '0;
					proto_q <= '0;
					dest_q <= '0;
					src_port_q <= '0;
					udp_length_q <= '0;
					if (!ok) begin
						out_q <= '{STATUS_IGNORED, 32'd0, 16'd0, 64'd0};
						out_valid_q <= 1'b1;
						state_q <= ST_RX;
					end else if (used_q == '0) begin
						state_q <= ST_WR;
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_CMP: begin
					if (rd_key_q == key_q) begin
						out_q <= '{STATUS_COUNTED, key_q[47:16], key_q[15:0], wr_cnt};
						state_q <= ST_OUT;
					end else if (idx_q + 1'b1 == used_q) begin
						state_q <= ST_WR;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_WAIT;
					end
				end
				ST_WR: begin
					if (used_q != FULL) begin
						used_q <= used_q + 1'b1;
						out_q <= '{STATUS_COUNTED, key_q[47:16], key_q[15:0], 64'd1};
					end else begin
						out_q <= '{STATUS_FULL, key_q[47:16], key_q[15:0], 64'd0};
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_RX;
				end
				ST_WAIT: state_q <= ST_CMP;
				default: state_q <= ST_RX;
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.status = out_q.status;
	assign out_ch.dest_addr = out_q.dest_addr;
	assign out_ch.payload_len = out_q.payload_len;
	assign out_ch.frame_count = out_q.frame_count;
endmodule

>>> tb/tb.sv
// self-checking testbench for udp_flow_size_counter with random frames and idling
module tb;
	import ufsc_pkg::*;

	localparam int FLOW_SLOTS = 1024;
	localparam int STALL_LIMIT = 6000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;
	logic        calm;
	logic        hold_req;
	int          hold_left;
	int          errors;
	int          quiet_cycles;

	ufsc_in_if  in_ch ();
	ufsc_out_if out_ch ();

	udp_flow_size_counter #(.TABLE_ENTRIES(FLOW_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	in_beat_t  pending_bytes[$];
	out_beat_t expected_results[$];

	// predictor copy of the block
	logic [15:0] lo_port, hi_port;
	logic [6:0]  pos_q;
	logic [15:0] etype_q;
	logic [3:0]  ihl_q;
	logic [7:0]  proto_q;
	logic [31:0] dest_q;
	logic [15:0] sport_q;
	logic [15:0] ulen_q;
	logic [47:0] flow_keys[FLOW_SLOTS];
	logic [63:0] flow_counts[FLOW_SLOTS];
	int          flows_used;

	// generator copy of the port range
	logic [15:0] gen_lo, gen_hi;
	logic [31:0] fresh_dest;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	function automatic void clear_capture();
		pos_q = '0;
		etype_q = '0;
		ihl_q = '0;
		proto_q = '0;
		dest_q = '0;
		sport_q = '0;
		ulen_q = '0;
	endfunction

	function automatic void predict_flow(input logic [7:0] b, input logic last);
		int        p;
		int        u;
		int        len;
		bit        ok;
		bit        hit;
		logic [15:0] pay;
		logic [47:0] key;
		out_beat_t   r;
		p = int'(pos_q);
		if (p == 12 || p == 13) etype_q = {etype_q[7:0], b};
		if (p == 14) ihl_q = b[3:0];
		if (p == 23) proto_q = b;
		if (p >= 30 && p <= 33) dest_q = {dest_q[23:0], b};
		if (ihl_q >= MIN_IHL && p > 14) begin
			u = 14 + 4 * ihl_q;
			if (p == u || p == u + 1) sport_q = {sport_q[7:0], b};
			if (p == u + 4 || p == u + 5) ulen_q = {ulen_q[7:0], b};
		end
		if (!last) begin
			if (pos_q < POS_MAX) pos_q = pos_q + 7'd1;
			return;
		end
		len = p + 1;
		ok = len >= 34 && etype_q == ETHERTYPE_IPV4 && proto_q == PROTO_UDP
			&& ihl_q >= MIN_IHL && len >= 14 + 4 * ihl_q + 8
			&& sport_q >= lo_port && sport_q <= hi_port && ulen_q >= UDP_HDR_LEN;
		r = '0;
		r.status = STATUS_IGNORED;
		if (ok) begin
			pay = ulen_q - UDP_HDR_LEN;
			key = {dest_q, pay};
			r.dest_addr = dest_q;
			r.payload_len = pay;
			hit = 1'b0;
			for (int i = 0; i < flows_used; i++) begin
				if (flow_keys[i] == key) begin
					flow_counts[i] = flow_counts[i] + 64'd1;
					r.status = STATUS_COUNTED;
					r.frame_count = flow_counts[i];
					hit = 1'b1;
					break;
				end
			end
			if (!hit) begin
				if (flows_used < FLOW_SLOTS) begin
					flow_keys[flows_used] = key;
					flow_counts[flows_used] = 64'd1;
					flows_used++;
					r.status = STATUS_COUNTED;
					r.frame_count = 64'd1;
				end else begin
					r.status = STATUS_FULL;
				end
			end
		end
		expected_results.push_back(r);
		clear_capture();
	endfunction

	task automatic push_frame(input logic [15:0] et, input logic [7:0] pr, input logic [3:0] ihl,
		input logic [31:0] da, input logic [15:0] sp, input logic [15:0] ul, input int len);
		logic [7:0] fb[];
		int         u;
		in_beat_t   beat;
		fb = new[len];
		for (int i = 0; i < len; i++) fb[i] = 8'($urandom_range(0, 255));
		u = 14 + 4 * ihl;
		if (len > 12) fb[12] = et[15:8];
		if (len > 13) fb[13] = et[7:0];
		if (len > 14) fb[14] = {fb[14][7:4], ihl};
		if (len > 23) fb[23] = pr;
		for (int i = 0; i < 4; i++) if (len > 30 + i) fb[30 + i] = da[31 - 8 * i -: 8];
		if (len > u) fb[u] = sp[15:8];
		if (len > u + 1) fb[u + 1] = sp[7:0];
		if (len > u + 4) fb[u + 4] = ul[15:8];
		if (len > u + 5) fb[u + 5] = ul[7:0];
		for (int i = 0; i < len; i++) begin
			beat.frame_byte = fb[i];
			beat.frame_end = (i == len - 1);
			pending_bytes.push_back(beat);
		end
	endtask

	function automatic logic [15:0] port_inside();
		if (gen_lo <= gen_hi) return 16'($urandom_range(gen_lo, gen_hi));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic random_frame();
		int          r;
		int          m;
		logic [3:0]  ihl;
		logic [31:0] da;
		logic [15:0] sp;
		logic [15:0] ul;
		logic [15:0] et;
		logic [7:0]  pr;
		int          need;
		int          len;
		r = $urandom_range(0, 99);
		ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
		da = ($urandom_range(0, 9) == 0) ? $urandom : 32'h0a00_0001 + $urandom_range(0, 7);
		sp = port_inside();
		ul = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(8, 65535))
			: 16'($urandom_range(8, 20));
		et = ETHERTYPE_IPV4;
		pr = PROTO_UDP;
		need = 14 + 4 * ihl + 8;
		len = need + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 90) : $urandom_range(0, 12));
		if (r < 65) begin
			push_frame(et, pr, ihl, da, sp, ul, len);
		end else if (r < 85) begin
			m = $urandom_range(0, 5);
			case (m)
				0: et = 16'($urandom_range(0, 65535)) ^ 16'h0001;
				1: pr = 8'd6;
				2: ihl = 4'($urandom_range(0, 4));
				3: len = int'($urandom_range(1, need - 1));
				4: begin
					if (gen_lo > 0) sp = gen_lo - 16'd1;
					else if (gen_hi < 16'hffff) sp = gen_hi + 16'd1;
					else sp = 16'($urandom_range(0, 65535));
				end
				default: ul = 16'($urandom_range(0, 7));
			endcase
			push_frame(et, pr, ihl, da, sp, ul, len);
		end else begin
			push_frame(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
				4'($urandom_range(0, 15)), $urandom, 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)), int'($urandom_range(1, 150)));
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_bytes.size() != 0 || in_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_ports(input logic [15:0] lo, input logic [15:0] hi);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_PORT_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= REG_PORT_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		gen_lo = lo;
		gen_hi = hi;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.frame_byte <= '0;
			in_ch.frame_end <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
				in_ch.valid <= 1'b1;
				in_ch.frame_byte <= pending_bytes[0].frame_byte;
				in_ch.frame_end <= pending_bytes[0].frame_end;
				void'(pending_bytes.pop_front());
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (hold_req) begin
			hold_left <= 400;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm || $urandom_range(0, 99) >= 12;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) predict_flow(in_ch.frame_byte, in_ch.frame_end);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					report("unexpected beat", 64'(out_ch.status), 64'd0);
				end else begin
					want = expected_results.pop_front();
					if (out_ch.status !== want.status)
						report("status", 64'(out_ch.status), 64'(want.status));
					if (out_ch.dest_addr !== want.dest_addr)
						report("dest_addr", 64'(out_ch.dest_addr), 64'(want.dest_addr));
					if (out_ch.payload_len !== want.payload_len)
						report("payload_len", 64'(out_ch.payload_len), 64'(want.payload_len));
					if (out_ch.frame_count !== want.frame_count)
						report("frame_count", out_ch.frame_count, want.frame_count);
				end
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] lo_set[6];
		logic [15:0] hi_set[6];
		errors = 0;
		quiet_cycles = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PORT_LOW;
		cfg_data = '0;
		lo_port = 16'd27960;
		hi_port = 16'd27963;
		gen_lo = lo_port;
		gen_hi = hi_port;
		flows_used = 0;
		fresh_dest = 32'he000_0000;
		clear_capture();
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames at reset port range
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 32'hffff_ffff, 16'd27960, 16'd8, 42);
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 32'hffff_ffff, 16'd27963, 16'd8, 42);
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd15, 32'h0000_0000, 16'd27961, 16'hffff, 82);
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 32'h0102_0304, 16'd27959, 16'd20, 50);
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 32'h0102_0304, 16'd27964, 16'd20, 50);
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 32'h0102_0304, 16'd27962, 16'd7, 50);
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd4, 32'h0102_0304, 16'd27962, 16'd20, 50);
		push_frame(ETHERTYPE_IPV4, 8'd6, 4'd5, 32'h0102_0304, 16'd27962, 16'd20, 50);
		push_frame(16'h86dd, PROTO_UDP, 4'd5, 32'h0102_0304, 16'd27962, 16'd20, 50);
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 32'h0102_0304, 16'd27962, 16'd20, 41);
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 32'h0102_0304, 16'd27962, 16'd20, 160);
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 32'h0102_0304, 16'd27962, 16'd20, 1);
		wait_idle();

		lo_set = '{16'd0, 16'hffff, 16'd0, 16'd40000, 16'd1000, 16'd27960};
		hi_set = '{16'hffff, 16'hffff, 16'd0, 16'd100, 16'd2000, 16'd27963};
		for (int ph = 0; ph < 6; ph++) begin
			write_ports(lo_set[ph], hi_set[ph]);
			lo_port = lo_set[ph];
			hi_port = hi_set[ph];
			calm = (ph == 2);
			for (int k = 0; k < 3; k++) random_frame();
			if (ph == 1) begin
				@(posedge clk);
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			wait_idle();
		end

		// a few fresh flows, then revisit known flows
		write_ports(16'd0, 16'hffff);
		lo_port = 16'd0;
		hi_port = 16'hffff;
		calm = 1'b0;
		for (int k = 0; k < 8; k++) begin
			push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, fresh_dest,
				16'($urandom_range(0, 65535)), 16'd8, 42);
			fresh_dest = fresh_dest + 32'd1;
		end
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 32'he000_0000, 16'd5, 16'd8, 42);
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 32'h0a00_0001, 16'd5, 16'd9, 42);
		push_frame(ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 32'hffff_fffe, 16'd5, 16'd30, 60);
		wait_idle();
		repeat (1100) @(posedge clk);

		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
